// ----- hw/rtl/spqe_pkg.sv -----
// Package for the scored priority queue with expiry.
// Holds the entry type, register indexes, controller states and the
// command and status groups between controller and datapath.
package spqe_pkg;

	localparam int DefQueueDepth = 32;
	localparam int MaxResults    = 32;
	localparam int KeyW          = 64;
	localparam int ScoreW        = 16;
	localparam int SumW          = 17;
	localparam int TimeW         = 32;
	localparam int HorizonW      = 16;
	localparam int EmitW         = 6;
	localparam int InDataW       = 224;
	localparam int OutDataW      = 152;
	localparam int CfgIdxW       = 2;
	localparam int CfgDataW      = 16;

	localparam logic [CfgIdxW-1:0] REG_MIN_SCORE  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_EMIT_COUNT = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_HORIZON    = 2'd2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	typedef struct packed {
		logic [SumW-1:0]  score;
		logic [KeyW-1:0]  source;
		logic [KeyW-1:0]  target;
		logic [TimeW-1:0] stamp;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INSERT,
		ST_TICK,
		ST_PRUNE,
		ST_PEND,
		ST_SETUP,
		ST_POP
	} state_t;

	typedef struct packed {
		logic load;
		logic insert;
		logic prune_start;
		logic prune_step;
		logic prune_end;
		logic pop;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic             count_zero;
		logic             left_one;
		logic             out_busy;
		logic [EmitW-1:0] pop_n;
	} status_t;

endpackage

// ----- hw/rtl/scored_priority_queue_with_expiry_core.sv -----
// Scored priority queue with expiry: keeps candidate key pairs sorted by
// descending combined score in a shifting cell chain of QUEUE_DEPTH entries.
// An insert beat passes the accept state and then the placement state. A
// tick on an empty queue ends at its start state. Otherwise a tick passes
// the accept state, the start state, the expiry sweep at one cell per cycle
// through the chain head, and the PEND and SETUP settle states. It then
// emits the entries one by one, holding while the sink stalls. The
// queue stalls new input until a tick has finished. Configuration writes
// are always ready, and only take effect safely while no beat is in flight.
module scored_priority_queue_with_expiry_core import spqe_pkg::*; #(
	parameter int QUEUE_DEPTH = DefQueueDepth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// tdata: source_key, target_key, source_score, target_score,
	// created_time, time_now (lowest bit first)
	input  logic [InDataW-1:0]  s_axis_tdata,
	// tuser: operation
	input  logic                s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// tdata: out_source_key, out_target_key, out_score, zero fill
	output logic [OutDataW-1:0] m_axis_tdata,
	output logic                m_axis_tlast,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;
	logic    full_over;

	assign cfg_ready = 1'b1;

	spqe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	spqe_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (s_axis_tdata),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.full_over (full_over)
	);

	// The fill count never passes the queue depth.
	assert property (@(posedge clk) disable iff (!arst_n) !full_over)
		else $error("queue fill count above depth");

	// A pop never happens on an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.pop |-> !status.count_zero)
		else $error("pop from empty queue");

	// A pop never overwrites a beat the sink has not taken.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.pop |-> !status.out_busy)
		else $error("output beat overwritten");

endmodule

// ----- hw/rtl/spqe_ctrl.sv -----
// Controller state machine for the scored priority queue.
// Depends on spqe_pkg; drives the datapath through cmd_t and reads status_t.
module spqe_ctrl import spqe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_op,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t           state_q, state_d;
	logic [EmitW-1:0] pop_left_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Count of entries still to pop in this tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_left_q <= '0;
		end else if (state_q == ST_SETUP) begin
			pop_left_q <= status.pop_n;
		end else if (cmd.pop) begin
			pop_left_q <= pop_left_q - EmitW'(1);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = (in_op == OP_TICK) ? ST_TICK : ST_INSERT;
			end
			ST_INSERT: state_d = ST_IDLE;
			ST_TICK: state_d = status.count_zero ? ST_IDLE : ST_PRUNE;
			ST_PRUNE: begin
				if (status.left_one) state_d = ST_PEND;
			end
			ST_PEND: state_d = ST_SETUP;
			ST_SETUP: state_d = (status.pop_n == '0) ? ST_IDLE : ST_POP;
			ST_POP: begin
				if (!status.out_busy && pop_left_q == EmitW'(1)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_INSERT: cmd.insert = 1'b1;
			ST_TICK: cmd.prune_start = !status.count_zero;
			ST_PRUNE: cmd.prune_step = 1'b1;
			ST_PEND: cmd.prune_end = 1'b1;
			ST_SETUP: ;
			ST_POP: begin
				cmd.pop  = !status.out_busy;
				cmd.last = (pop_left_q == EmitW'(1));
			end
			default: ;
		endcase
	end

endmodule

// ----- hw/rtl/spqe_dp.sv -----
// Datapath for the scored priority queue: sorted shifting cell chain,
// item register, configuration registers and output register. Uses spqe_pkg.
module spqe_dp import spqe_pkg::*; #(
	parameter int QUEUE_DEPTH = DefQueueDepth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output status_t             status,
	input  logic [InDataW-1:0]  in_data,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output logic [OutDataW-1:0] out_data,
	output logic                out_last,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                full_over
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int MW = (CW > EmitW) ? CW : EmitW;

	entry_t              cell_q [QUEUE_DEPTH];
	entry_t              cell_d [QUEUE_DEPTH];
	logic [CW-1:0]       count_q, left_q, kept_q;
	logic [ScoreW-1:0]   min_q, s0_q, s1_q;
	logic [EmitW-1:0]    emit_q;
	logic [HorizonW-1:0] horizon_q;
	logic [KeyW-1:0]     src_q, tgt_q;
	logic [TimeW-1:0]    stamp_q, now_q;
	entry_t              out_q;
	logic                out_last_q, out_valid_q;

	logic [SumW-1:0]       new_score;
	logic                  ins_drop;
	logic [QUEUE_DEPTH-1:0] gt;
	logic                  alive;
	logic [CW-1:0]         wpos_full;
	logic [IW-1:0]         wpos;
	logic [EmitW-1:0]      cap;
	entry_t                new_entry;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q     <= '0;
			emit_q    <= EmitW'(1);
			horizon_q <= HorizonW'(60);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_SCORE:  min_q     <= cfg_data;
				REG_EMIT_COUNT: emit_q    <= cfg_data[EmitW-1:0];
				REG_HORIZON:    horizon_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Item register, captured when the input beat is taken.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			src_q   <= in_data[63:0];
			tgt_q   <= in_data[127:64];
			s0_q    <= in_data[143:128];
			s1_q    <= in_data[159:144];
			stamp_q <= in_data[191:160];
			now_q   <= in_data[223:192];
		end
	end

	// Insert decision and per-cell placement compare.
	assign new_score = {1'b0, s0_q} + {1'b0, s1_q};
	assign new_entry = '{score: new_score, source: src_q, target: tgt_q, stamp: stamp_q};
	assign ins_drop  = (s0_q < min_q) || (s1_q < min_q) ||
		((count_q == CW'(QUEUE_DEPTH)) && (new_score <= cell_q[QUEUE_DEPTH-1].score));

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			gt[i] = (CW'(i) < count_q) && (new_score < cell_q[i].score);
		end
	end

	// Expiry check on the head cell and write slot for a kept entry.
	assign alive = ({1'b0, cell_q[0].stamp} + {17'b0, horizon_q}) > {1'b0, now_q};
	assign wpos_full = left_q - CW'(1) + kept_q;
	assign wpos = wpos_full[IW-1:0];

	// Next value of each cell.
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			cell_d[i] = cell_q[i];
			if (cmd.insert && !ins_drop) begin
				if (!gt[i]) begin
					if (i == 0) cell_d[i] = new_entry;
					else if (gt[i-1]) cell_d[i] = new_entry;
					else cell_d[i] = cell_q[i-1];
				end
			end else if (cmd.prune_step) begin
				if (IW'(i) == wpos && alive) cell_d[i] = cell_q[0];
				else if (i < QUEUE_DEPTH - 1) cell_d[i] = cell_q[i+1];
			end else if (cmd.pop) begin
				if (i < QUEUE_DEPTH - 1) cell_d[i] = cell_q[i+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			cell_q[i] <= cell_d[i];
		end
	end

	// Fill count and prune counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			left_q  <= '0;
			kept_q  <= '0;
		end else begin
			if (cmd.insert && !ins_drop && count_q != CW'(QUEUE_DEPTH)) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.prune_end) begin
				count_q <= kept_q;
			end else if (cmd.pop) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.prune_start) begin
				left_q <= count_q;
				kept_q <= '0;
			end else if (cmd.prune_step) begin
				left_q <= left_q - CW'(1);
				kept_q <= kept_q + CW'(alive);
			end
		end
	end

	// Output register; the head beat waits here while the sink stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			out_q      <= cell_q[0];
			out_last_q <= cmd.last;
		end
	end

	assign out_data  = {7'b0, out_q.score, out_q.target, out_q.source};
	assign out_last  = out_last_q;
	assign out_valid = out_valid_q;
	assign full_over = count_q > CW'(QUEUE_DEPTH);

	// Pops per tick: emit count, capped, and no more than the fill.
	assign cap = (emit_q > EmitW'(MaxResults)) ? EmitW'(MaxResults) : emit_q;

	always_comb begin
		status.count_zero = (count_q == '0);
		status.left_one   = (left_q == CW'(1));
		status.out_busy   = out_valid_q && !out_ready;
		if (MW'(count_q) < MW'(cap)) status.pop_n = EmitW'(count_q);
		else status.pop_n = cap;
	end

endmodule
